### src/tghl_pkg.sv
package tghl_pkg;

    localparam int CELL_MAX = 1024;
    localparam int CELL_BITS = 11;
    localparam int COORD_BITS = 16;
    localparam int OUT_BITS = 24;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        REG_GRID_POINTS = 1'b0,
        REG_CELL_SIZE   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  grid_row;
        logic [5:0]  grid_col;
        logic [15:0] height_value;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] height_q8;
        logic               outside;
    } out_item_t;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  grid_row;
        logic [5:0]  grid_col;
        logic [15:0] height_value;
        logic        outside;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [10:0] cs;
        logic [7:0]  gp_m1;
    } job_t;

endpackage

### src/tghl_front.sv
module tghl_front
#(
    parameter int GRID_MAX = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [10:0]          cfg_data,
    input  logic                 start,
    input  tghl_pkg::in_item_t   item,
    output logic                 busy,
    output logic                 job_valid,
    output tghl_pkg::job_t       job,
    input  logic                 job_ready
);
    import tghl_pkg::*;

    localparam int GP_W = $clog2(GRID_MAX + 1);

    logic [6:0]  grid_points_reg;
    logic [10:0] cell_size_reg;
    logic [10:0] cs;
    logic [7:0]  gp_m1;
    logic [18:0] ext;
    logic        outside;

    job_t        q_reg [QUEUE_DEPTH];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;
    logic        push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_points_reg <= 7'd64;
            cell_size_reg <= 11'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_POINTS: grid_points_reg <= cfg_data[6:0];
                REG_CELL_SIZE:   cell_size_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // saturate registers to legal range
    always_comb
    begin
        logic [GP_W-1:0] gp;
        if (grid_points_reg < 7'd2)
            gp = GP_W'(2);
        else if (32'(grid_points_reg) > GRID_MAX)
            gp = GP_W'(GRID_MAX);
        else
            gp = GP_W'(grid_points_reg);
        gp_m1 = 8'(gp - GP_W'(1));
        if (cell_size_reg == 11'd0)
            cs = 11'd1;
        else if (cell_size_reg > 11'(CELL_MAX))
            cs = 11'(CELL_MAX);
        else
            cs = cell_size_reg;
        ext = 19'(cs) * 19'(gp_m1);
        outside = (19'(item.x_coord) > ext) || (19'(item.y_coord) > ext);
    end

    assign busy = (count_reg == 3'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign pop = job_valid && job_ready;
    assign job_valid = (count_reg != 3'd0);
    assign job = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{opcode: item.opcode, grid_row: item.grid_row,
                                   grid_col: item.grid_col,
                                   height_value: item.height_value,
                                   outside: outside, x_coord: item.x_coord,
                                   y_coord: item.y_coord, cs: cs, gp_m1: gp_m1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

### src/tghl_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
module tghl_divider
#(
    parameter int N_BITS = 16,
    parameter int D_BITS = 11,
    parameter int TAG_BITS = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [N_BITS-1:0]   num,
    input  logic [D_BITS-1:0]   den,
    input  logic [TAG_BITS-1:0] tag,
    output logic                out_valid,
    output logic [N_BITS-1:0]   quot,
    output logic [D_BITS-1:0]   rem,
    output logic [TAG_BITS-1:0] out_tag
);
    for (genvar s = 0; s < N_BITS; s++)
    begin : g_stage
        logic                v_in, v_reg;
        logic [N_BITS-1:0]   n_in, n_reg;
        logic [D_BITS:0]     r_in, r_reg;
        logic [D_BITS-1:0]   d_in, d_reg;
        logic [TAG_BITS-1:0] t_in, t_reg;
        logic [D_BITS+1:0]   trial;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign n_in = num;
            assign r_in = '0;
            assign d_in = den;
            assign t_in = tag;
        end
        else
        begin : g_next
            assign v_in = g_stage[s-1].v_reg;
            assign n_in = g_stage[s-1].n_reg;
            assign r_in = g_stage[s-1].r_reg;
            assign d_in = g_stage[s-1].d_reg;
            assign t_in = g_stage[s-1].t_reg;
        end

        assign trial = {r_in, n_in[N_BITS-1]} - {2'b00, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= v_in;
        end

        always_ff @(posedge clk)
        begin
            d_reg <= d_in;
            t_reg <= t_in;
            if (!trial[D_BITS+1])
            begin
                r_reg <= trial[D_BITS:0];
                n_reg <= {n_in[N_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_in[D_BITS-1:0], n_in[N_BITS-1]};
                n_reg <= {n_in[N_BITS-2:0], 1'b0};
            end
        end
    end

    assign out_valid = g_stage[N_BITS-1].v_reg;
    assign quot = g_stage[N_BITS-1].n_reg;
    assign rem = g_stage[N_BITS-1].r_reg[D_BITS-1:0];
    assign out_tag = g_stage[N_BITS-1].t_reg;
endmodule

### src/tghl_back.sv
module tghl_back
#(
    parameter int GRID_MAX = 64,
    parameter int HEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  tghl_pkg::job_t      job,
    output logic                job_ready,
    output logic                done,
    output tghl_pkg::out_item_t result
);
    import tghl_pkg::*;

    localparam int IDX_W = $clog2(GRID_MAX);
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DIFF_W = HEIGHT_BITS + 1;
    localparam int PROD_W = DIFF_W + 12;
    localparam int SUM_W = PROD_W + 1;
    localparam int NUM_W = SUM_W + 8;
    localparam int NMAG_W = NUM_W;

    assign job_ready = 1'b1;

    // coordinate dividers; writes ride along so they keep their order with reads
    localparam int TAG_W = 1 + 1 + 11 + 8 + 6 + 6 + 16;
    localparam int YTAG_W = 11 + 8;
    logic [TAG_W-1:0] dtag_in, dtag_x;
    logic [YTAG_W-1:0] ytag_in, dtag_y;
    logic dv_x, dv_y;
    logic [15:0] qx, qy;
    logic [10:0] rx_raw, ry_raw;
    assign dtag_in = {job.opcode, job.outside, job.cs, job.gp_m1, job.grid_row,
                      job.grid_col, job.height_value};
    assign ytag_in = {job.cs, job.gp_m1};

    tghl_divider #(.N_BITS(16), .D_BITS(11), .TAG_BITS(TAG_W)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_valid(job_valid), .num(job.x_coord), .den(job.cs),
        .tag(dtag_in), .out_valid(dv_x), .quot(qx), .rem(rx_raw), .out_tag(dtag_x)
    );
    tghl_divider #(.N_BITS(16), .D_BITS(11), .TAG_BITS(YTAG_W)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_valid(job_valid), .num(job.y_coord), .den(job.cs),
        .tag(ytag_in), .out_valid(dv_y), .quot(qy), .rem(ry_raw), .out_tag(dtag_y)
    );

    // stage A: apply writes, clamp, pick triangle, issue reads
    logic        op_a, out_a;
    logic [10:0] cs_a, cs_ya;
    logic [7:0]  gpm1_a, gpm1_ya;
    logic [5:0]  row_a, col_a;
    logic [15:0] hv_a;
    assign op_a = dtag_x[TAG_W-1];
    assign out_a = dtag_x[TAG_W-2];
    assign cs_a = dtag_x[TAG_W-3 -: 11];
    assign gpm1_a = dtag_x[TAG_W-14 -: 8];
    assign row_a = dtag_x[TAG_W-22 -: 6];
    assign col_a = dtag_x[TAG_W-28 -: 6];
    assign hv_a = dtag_x[15:0];
    assign cs_ya = dtag_y[YTAG_W-1 -: 11];
    assign gpm1_ya = dtag_y[7:0];

    // height writes land here; three banked copies give three reads a cycle
    logic signed [HEIGHT_BITS-1:0] mem0 [DEPTH];
    logic signed [HEIGHT_BITS-1:0] mem1 [DEPTH];
    logic signed [HEIGHT_BITS-1:0] mem2 [DEPTH];

    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    assign wr_en = dv_x && (op_a == OP_WRITE)
                   && (32'(row_a) < GRID_MAX) && (32'(col_a) < GRID_MAX);
    assign wr_addr = {IDX_W'(row_a), IDX_W'(col_a)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem0[wr_addr] <= HEIGHT_BITS'(signed'(hv_a));
            mem1[wr_addr] <= HEIGHT_BITS'(signed'(hv_a));
            mem2[wr_addr] <= HEIGHT_BITS'(signed'(hv_a));
        end
    end

    logic [15:0] cxc, cyc;
    logic [11:0] rxc, ryc;
    logic        upper;
    logic [IDX_W-1:0] cxi, cyi, cxi1, cyi1;

    always_comb
    begin
        if (qx >= 16'(gpm1_a))
        begin
            cxc = 16'(gpm1_a) - 16'd1;
            rxc = 12'(cs_a);
        end
        else
        begin
            cxc = qx;
            rxc = 12'(rx_raw);
        end
        if (qy >= 16'(gpm1_ya))
        begin
            cyc = 16'(gpm1_ya) - 16'd1;
            ryc = 12'(cs_ya);
        end
        else
        begin
            cyc = qy;
            ryc = 12'(ry_raw);
        end
        upper = (13'(rxc) + 13'(ryc)) >= 13'(cs_a);
        cxi = IDX_W'(cxc);
        cyi = IDX_W'(cyc);
        cxi1 = IDX_W'(cxc + 16'd1);
        cyi1 = IDX_W'(cyc + 16'd1);
    end

    logic        v_b_reg, out_b_reg;
    logic [10:0] cs_b_reg;
    logic [11:0] wx_b_reg, wy_b_reg;
    logic signed [HEIGHT_BITS-1:0] h0_b_reg, h1_b_reg, h2_b_reg;

    always_ff @(posedge clk)
    begin
        h0_b_reg <= upper ? mem0[{cyi1, cxi1}] : mem0[{cyi, cxi}];
        h1_b_reg <= upper ? mem1[{cyi, cxi1}] : mem1[{cyi1, cxi}];
        h2_b_reg <= upper ? mem2[{cyi1, cxi}] : mem2[{cyi, cxi1}];
        out_b_reg <= out_a;
        cs_b_reg <= cs_a;
        wx_b_reg <= upper ? 12'(cs_a) - rxc : rxc;
        wy_b_reg <= upper ? 12'(cs_a) - ryc : ryc;
    end

    // stage C: differences times weights
    logic        v_c_reg, out_c_reg;
    logic [10:0] cs_c_reg;
    logic signed [HEIGHT_BITS-1:0] h0_c_reg;
    logic signed [PROD_W-1:0] p1_c_reg, p2_c_reg;

    always_ff @(posedge clk)
    begin
        p1_c_reg <= PROD_W'((DIFF_W'(h1_b_reg) - DIFF_W'(h0_b_reg))
                            * $signed({1'b0, wy_b_reg}));
        p2_c_reg <= PROD_W'((DIFF_W'(h2_b_reg) - DIFF_W'(h0_b_reg))
                            * $signed({1'b0, wx_b_reg}));
        h0_c_reg <= h0_b_reg;
        out_c_reg <= out_b_reg;
        cs_c_reg <= cs_b_reg;
    end

    // stage D: sum, magnitude for the divider
    logic signed [NUM_W-1:0] num_d;
    logic [NMAG_W-1:0] mag_d;
    logic neg_d;
    assign num_d = NUM_W'(SUM_W'(p1_c_reg) + SUM_W'(p2_c_reg)) <<< 8;
    assign neg_d = num_d[NUM_W-1];
    assign mag_d = neg_d ? NMAG_W'(-num_d) : NMAG_W'(num_d);

    localparam int T2_W = 1 + 1 + HEIGHT_BITS;
    logic dv_q;
    logic [NMAG_W-1:0] qmag;
    logic [10:0] rem_unused;
    logic [T2_W-1:0] t2_in, t2_out;
    assign t2_in = {out_c_reg, neg_d, h0_c_reg};

    tghl_divider #(.N_BITS(NMAG_W), .D_BITS(11), .TAG_BITS(T2_W)) u_div_q (
        .clk(clk), .rst_n(rst_n), .in_valid(v_c_reg), .num(mag_d), .den(cs_c_reg),
        .tag(t2_in), .out_valid(dv_q), .quot(qmag), .rem(rem_unused), .out_tag(t2_out)
    );

    // stage E: final Q8 value
    logic signed [HEIGHT_BITS-1:0] h0_e;
    logic signed [OUT_BITS-1:0] qs_e;
    assign h0_e = t2_out[HEIGHT_BITS-1:0];
    assign qs_e = t2_out[HEIGHT_BITS] ? -OUT_BITS'(qmag) : OUT_BITS'(qmag);

    logic                done_reg;
    out_item_t           result_reg;

    always_ff @(posedge clk)
    begin
        if (t2_out[T2_W-1])
        begin
            result_reg.height_q8 <= '0;
            result_reg.outside <= 1'b1;
        end
        else
        begin
            result_reg.height_q8 <= (OUT_BITS'(h0_e) <<< 8) + qs_e
                                    + OUT_BITS'(rem_unused & 11'd0);
            result_reg.outside <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_b_reg <= dv_x && dv_y && (op_a == OP_QUERY);
            v_c_reg <= v_b_reg;
            done_reg <= dv_q;
        end
    end

    assign done = done_reg;
    assign result = result_reg;
endmodule

### src/triangle_grid_height_lookup_unit.sv
// A query result is strobed once it has passed the front queue, 16 coordinate divider stages,
// the stage B and C registers, 38 quotient divider stages and the result register.
// Throughput: one item per cycle; the back end never stalls, so busy stays low.
// Writes give no result and reach the memory in the slot where a query reads.
// Reset: asynchronous, active low; sets 64 points and cell size 16.
// Height memory is not cleared; the receiver cannot stall results.
module triangle_grid_height_lookup_unit
#(
    parameter int GRID_MAX = 64,
    parameter int HEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [10:0]         cfg_data,
    input  logic                start,
    input  tghl_pkg::in_item_t  item,
    output logic                busy,
    output logic                done,
    output tghl_pkg::out_item_t result
);
    import tghl_pkg::*;

    logic job_valid, job_ready;
    job_t job;

    tghl_front #(.GRID_MAX(GRID_MAX)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .item(item), .busy(busy),
        .job_valid(job_valid), .job(job), .job_ready(job_ready)
    );

    tghl_back #(.GRID_MAX(GRID_MAX), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_ready(job_ready), .done(done), .result(result)
    );
endmodule
